FILE: rtl/nmpc_pkg.sv
package nmpc_pkg;

	typedef logic signed [47:0] val_t;
	typedef logic [63:0] coef_t;
	typedef logic signed [49:0] wsum_t;

	typedef enum logic [1:0] {
		FUNC_PREDICT = 2'd0,
		FUNC_ACCEL   = 2'd1,
		FUNC_VEL     = 2'd2,
		FUNC_DISP    = 2'd3
	} func_t;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_ALPHA     = 2'd1;
	localparam logic [1:0] REG_BETA      = 2'd2;

	localparam logic [31:0] TIME_STEP_RST = 32'd4294967;
	localparam logic [17:0] ALPHA_RST     = 18'd32768;
	localparam logic [17:0] BETA_RST      = 18'd32768;

	// 1.0 in unsigned Q32.32
	localparam coef_t COEF_ONE = 64'h0000_0001_0000_0000;

	localparam int SCALE_LAT = 5;

	typedef struct packed {
		val_t val;
		logic sat;
	} scale_res_t;

	function automatic wsum_t sext50(input val_t x);
		return 50'(x);
	endfunction

	// saturate a 50-bit sum to the 48-bit range
	function automatic scale_res_t clip48(input wsum_t s);
		scale_res_t r;
		logic pos_ovf;
		logic neg_ovf;
		pos_ovf = !s[49] && (s[48] || s[47]);
		neg_ovf = s[49] && !(s[48] && s[47]);
		r.sat = pos_ovf || neg_ovf;
		if (pos_ovf)
			r.val = 48'sh7FFF_FFFF_FFFF;
		else if (neg_ovf)
			r.val = 48'sh8000_0000_0000;
		else
			r.val = s[47:0];
		return r;
	endfunction

endpackage

FILE: rtl/nmpc_scale.sv
module nmpc_scale (
	input  logic                  clk,
	input  nmpc_pkg::val_t        x,
	input  nmpc_pkg::coef_t       coef,
	input  logic                  shift33,
	output nmpc_pkg::scale_res_t  res
);
	import nmpc_pkg::*;

	localparam int MAG_W  = 48;
	localparam int HALF_W = MAG_W / 2;
	localparam int PP_W   = HALF_W + 32;
	localparam int PS_W   = PP_W + HALF_W + 1;
	localparam int PROD_W = MAG_W + 64 + 1;
	localparam int Q_W    = PROD_W - 32;

	logic               neg_s1, sh_s1;
	logic [MAG_W-1:0]   mag_s1;
	coef_t              coef_s1;

	logic               neg_s2, sh_s2;
	logic [PP_W-1:0]    pp00_s2, pp01_s2, pp10_s2, pp11_s2;

	logic               neg_s3, sh_s3;
	logic [PS_W-1:0]    lo_s3, hi_s3;

	logic               neg_s4, sh_s4;
	logic [PROD_W-1:0]  p_s4;

	scale_res_t         res_s5;

	logic [Q_W-1:0]     q;
	logic               ovf;
	logic [MAG_W-1:0]   m;
	logic [MAG_W-1:0]   lim;

	always_comb begin
		q   = sh_s4 ? Q_W'(p_s4 >> 33) : Q_W'(p_s4 >> 32);
		ovf = (|q[Q_W-1:MAG_W]) || (q[MAG_W-1] && (!neg_s4 || (|q[MAG_W-2:0])));
		lim = neg_s4 ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		m   = ovf ? lim : q[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		neg_s1  <= x[MAG_W-1];
		mag_s1  <= x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
		coef_s1 <= coef;
		sh_s1   <= shift33;

		neg_s2  <= neg_s1;
		sh_s2   <= sh_s1;
		pp00_s2 <= PP_W'(mag_s1[HALF_W-1:0]) * PP_W'(coef_s1[31:0]);
		pp01_s2 <= PP_W'(mag_s1[HALF_W-1:0]) * PP_W'(coef_s1[63:32]);
		pp10_s2 <= PP_W'(mag_s1[MAG_W-1:HALF_W]) * PP_W'(coef_s1[31:0]);
		pp11_s2 <= PP_W'(mag_s1[MAG_W-1:HALF_W]) * PP_W'(coef_s1[63:32]);

		neg_s3  <= neg_s2;
		sh_s3   <= sh_s2;
		lo_s3   <= PS_W'(pp00_s2) + (PS_W'(pp10_s2) << HALF_W);
		hi_s3   <= PS_W'(pp01_s2) + (PS_W'(pp11_s2) << HALF_W);

		neg_s4  <= neg_s3;
		sh_s4   <= sh_s3;
		p_s4    <= PROD_W'(lo_s3) + (PROD_W'(hi_s3) << 32)
			+ (sh_s3 ? (PROD_W'(1) << 32) : (PROD_W'(1) << 31));

		res_s5.val <= neg_s4 ? val_t'(-m) : val_t'(m);
		res_s5.sat <= ovf;
	end

	assign res = res_s5;

endmodule

FILE: rtl/newmark_predictor_corrector.sv
// Newmark-beta predictor/corrector, one degree of freedom per transfer. An item is
// taken at every clock edge with start high and busy low, one per cycle with no gaps;
// its result appears on the output ports with done high for exactly one
// cycle, and the receiver cannot stall. Between input and output lie two chained 5-stage 48x64
// multiply-round units (the predictor's dt/2*(dt*a) term) plus an output stage.
// The corrector coefficients are held in registers and rebuilt by a serial unit after
// reset and after every register write: three multiply steps and three 64-step
// restoring divisions, during which busy is high.
module newmark_predictor_corrector (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  nmpc_pkg::val_t        disp_in,
	input  nmpc_pkg::val_t        vel_in,
	input  nmpc_pkg::val_t        accel_in,
	input  nmpc_pkg::val_t        correction,
	input  logic                  is_fixed,

	output logic                  done,
	output nmpc_pkg::val_t        disp_out,
	output nmpc_pkg::val_t        vel_out,
	output nmpc_pkg::val_t        accel_out,
	output logic                  saturated,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import nmpc_pkg::*;

	localparam int PIPE_N = 2 * SCALE_LAT;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL1  = 6'b000010,
		ST_MUL2  = 6'b000100,
		ST_MUL3  = 6'b001000,
		ST_DLOAD = 6'b010000,
		ST_DIV   = 6'b100000
	} seq_state_t;

	typedef enum logic [1:0] {
		DIV_C2 = 2'd0,
		DIV_D3 = 2'd1,
		DIV_C3 = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic [1:0] func;
		logic       fixed;
		val_t       u;
		val_t       v;
		val_t       a;
		val_t       corr;
		logic       csat;
		val_t       ra;
		logic       ra_sat;
		val_t       rb;
		logic       rb_sat;
	} item_t;

	localparam logic [99:0] INIT_K80  = 100'd1 << 16;
	localparam logic [99:0] INIT_K128 = 100'd1 << 64;

	// configuration registers
	logic [31:0] time_step_q;
	logic [17:0] alpha_q;
	logic [17:0] beta_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[3:2] == REG_TIME_STEP || paddr[3:2] == REG_ALPHA || paddr[3:2] == REG_BETA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			alpha_q     <= ALPHA_RST;
			beta_q      <= BETA_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_TIME_STEP: time_step_q <= pwdata;
				REG_ALPHA:     alpha_q     <= pwdata[17:0];
				REG_BETA:      beta_q      <= pwdata[17:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TIME_STEP: prdata = time_step_q;
			REG_ALPHA:     prdata = 32'(alpha_q);
			REG_BETA:      prdata = 32'(beta_q);
			default:       prdata = '0;
		endcase
	end

	// coefficient sequencer
	seq_state_t  state_q;
	div_sel_t    div_sel_q;
	logic [5:0]  cnt_q;

	logic [49:0] bt_q, at_q;
	logic [35:0] ab_q;
	logic [63:0] tt_q;
	logic [67:0] pl_q, ph_q;
	logic [99:0] den3_q;
	logic [33:0] d1_q, e2_q;
	coef_t       c2_q, d3_q, c3_q;
	logic        c2_sat_q, d3_sat_q, c3_sat_q;

	logic [99:0] rem_q, den_q;
	logic [63:0] quo_q;
	logic        dsat_q;

	logic [99:0] ld_den, ld_init;
	logic [100:0] rem2;
	logic [101:0] diff;
	logic        ge;
	coef_t       quo_fin;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		case (div_sel_q)
			DIV_C2: begin
				ld_den  = 100'(bt_q);
				ld_init = INIT_K80;
			end
			DIV_D3: begin
				ld_den  = 100'(at_q);
				ld_init = INIT_K80;
			end
			default: begin
				ld_den  = den3_q;
				ld_init = INIT_K128;
			end
		endcase
		rem2    = {rem_q, 1'b0};
		diff    = {1'b0, rem2} - {2'b0, den_q};
		ge      = !diff[101];
		quo_fin = dsat_q ? '1 : {quo_q[62:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_MUL1;
			div_sel_q <= DIV_C2;
			cnt_q     <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_MUL1;
		end else begin
			case (state_q)
				ST_IDLE: begin
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: begin
					state_q   <= ST_DLOAD;
					div_sel_q <= DIV_C2;
				end
				ST_DLOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= '1;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						if (div_sel_q == DIV_C3) begin
							state_q <= ST_IDLE;
						end else begin
							div_sel_q <= (div_sel_q == DIV_C2) ? DIV_D3 : DIV_C3;
							state_q   <= ST_DLOAD;
						end
					end
				end
				default: state_q <= ST_MUL1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1) begin
			bt_q <= 50'(beta_q) * 50'(time_step_q);
			at_q <= 50'(alpha_q) * 50'(time_step_q);
			ab_q <= 36'(alpha_q) * 36'(beta_q);
			tt_q <= 64'(time_step_q) * 64'(time_step_q);
		end
		if (state_q == ST_MUL2) begin
			pl_q <= 68'(ab_q) * 68'(tt_q[31:0]);
			ph_q <= 68'(ab_q) * 68'(tt_q[63:32]);
		end
		if (state_q == ST_MUL3) begin
			den3_q <= 100'(pl_q) + {ph_q, 32'b0};
			d1_q   <= bt_q[49:16];
			e2_q   <= at_q[49:16];
		end
		if (state_q == ST_DLOAD) begin
			den_q  <= ld_den;
			rem_q  <= ld_init;
			quo_q  <= '0;
			dsat_q <= (ld_den == '0) || (ld_den <= ld_init);
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? diff[99:0] : rem2[99:0];
			quo_q <= {quo_q[62:0], ge};
			if (cnt_q == '0) begin
				case (div_sel_q)
					DIV_C2: begin
						c2_q     <= quo_fin;
						c2_sat_q <= dsat_q;
					end
					DIV_D3: begin
						d3_q     <= quo_fin;
						d3_sat_q <= dsat_q;
					end
					default: begin
						c3_q     <= quo_fin;
						c3_sat_q <= dsat_q;
					end
				endcase
			end
		end
	end

	// datapath
	logic       accept;
	val_t       x_a, x_b, x_c;
	coef_t      coef_a, coef_b, coef_c;
	logic       csat_in;
	logic       pred_c;
	item_t      item_in;
	item_t      item_mid;
	scale_res_t lane_a, lane_b, lane_c;

	item_t             item_s [1:PIPE_N];
	logic [PIPE_N:1]   vld_s;

	assign accept = start && !busy;

	always_comb begin
		x_a     = correction;
		x_b     = correction;
		csat_in = 1'b0;
		case (func)
			FUNC_PREDICT: begin
				x_a    = accel_in;
				x_b    = vel_in;
				coef_a = 64'(time_step_q);
				coef_b = 64'(time_step_q);
			end
			FUNC_ACCEL: begin
				coef_a = COEF_ONE;
				coef_b = 64'(d1_q);
			end
			FUNC_VEL: begin
				coef_a  = c2_q;
				coef_b  = COEF_ONE;
				csat_in = c2_sat_q;
			end
			default: begin
				coef_a  = c3_q;
				coef_b  = d3_q;
				csat_in = c3_sat_q || d3_sat_q;
			end
		endcase

		item_in        = '0;
		item_in.func   = func;
		item_in.fixed  = is_fixed;
		item_in.u      = disp_in;
		item_in.v      = vel_in;
		item_in.a      = accel_in;
		item_in.corr   = correction;
		item_in.csat   = csat_in;
	end

	always_comb begin
		pred_c = (item_s[SCALE_LAT].func == FUNC_PREDICT);
		x_c    = pred_c ? lane_a.val : item_s[SCALE_LAT].corr;
		case (item_s[SCALE_LAT].func)
			FUNC_PREDICT: coef_c = 64'(time_step_q);
			FUNC_ACCEL:   coef_c = 64'(den3_q[99:64]);
			FUNC_VEL:     coef_c = 64'(e2_q);
			default:      coef_c = COEF_ONE;
		endcase
	end

	always_comb begin
		item_mid        = item_s[SCALE_LAT];
		item_mid.ra     = lane_a.val;
		item_mid.ra_sat = lane_a.sat;
		item_mid.rb     = lane_b.val;
		item_mid.rb_sat = lane_b.sat;
	end

	nmpc_scale u_lane_a (
		.clk     (clk),
		.x       (x_a),
		.coef    (coef_a),
		.shift33 (1'b0),
		.res     (lane_a)
	);

	nmpc_scale u_lane_b (
		.clk     (clk),
		.x       (x_b),
		.coef    (coef_b),
		.shift33 (1'b0),
		.res     (lane_b)
	);

	nmpc_scale u_lane_c (
		.clk     (clk),
		.x       (x_c),
		.coef    (coef_c),
		.shift33 (pred_c),
		.res     (lane_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[PIPE_N-1:1], accept};
	end

	always_ff @(posedge clk) begin
		item_s[1] <= item_in;
		for (int k = 2; k <= PIPE_N; k++) begin
			if (k == SCALE_LAT + 1)
				item_s[k] <= item_mid;
			else
				item_s[k] <= item_s[k-1];
		end
	end

	// final sums
	item_t      it;
	logic       pred_f;
	scale_res_t cu, cv, ca;
	logic       sat_f;

	always_comb begin
		it     = item_s[PIPE_N];
		pred_f = (it.func == FUNC_PREDICT);
		cu = clip48(sext50(it.u) + sext50(pred_f ? it.rb : val_t'(0)) + sext50(lane_c.val));
		cv = clip48(sext50(it.v) + sext50(pred_f ? it.ra : it.rb));
		ca = clip48(sext50(it.a) + sext50(pred_f ? val_t'(0) : it.ra));
		sat_f = it.csat || it.ra_sat || it.rb_sat || lane_c.sat || cu.sat || cv.sat || ca.sat;
	end

	logic done_q;
	val_t disp_q, vel_q, accel_q;
	logic sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s[PIPE_N];
	end

	always_ff @(posedge clk) begin
		disp_q  <= it.fixed ? it.u : cu.val;
		vel_q   <= it.fixed ? it.v : cv.val;
		accel_q <= it.fixed ? it.a : ca.val;
		sat_q   <= !it.fixed && sat_f;
	end

	assign done      = done_q;
	assign disp_out  = disp_q;
	assign vel_out   = vel_q;
	assign accel_out = accel_q;
	assign saturated = sat_q;

endmodule
